### rtl/core/fsc_pkg.sv
package fsc_pkg;

    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned PERIOD_IN_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SETPOINT      = 8'd0,
        REG_GAIN_PROP     = 8'd1,
        REG_GAIN_INTEGRAL = 8'd2,
        REG_GAIN_DERIV    = 8'd3
    } cfg_reg_t;

    localparam logic [15:0] SETPOINT_RST      = 16'd1000;
    localparam logic [15:0] GAIN_PROP_RST     = 16'd1024;
    localparam logic [15:0] GAIN_INTEGRAL_RST = 16'd64;
    localparam logic [15:0] GAIN_DERIV_RST    = 16'd77;

    // 62500 ticks/s * 60 s/min
    localparam int unsigned NUM_W = 22;
    localparam logic [NUM_W-1:0] SPEED_NUM = 22'd3750000;
    localparam logic [15:0] SPEED_MAX = 16'hFFFF;

    // +/-50 in Q8.8
    localparam logic signed [15:0] I_LIMIT = 16'sd12800;

    // 0.0853 ~= 5590 / 65536
    localparam logic [15:0] SCOPE_MUL = 16'd5590;
    localparam logic [7:0]  LEVEL_MAX = 8'hFF;
    // smallest speed whose scope level saturates
    localparam logic [15:0] SCOPE_SAT_SPEED = 16'd2990;

    localparam int unsigned OUT_W = 32;

endpackage

### rtl/core/fan_speed_pid_controller_top.sv
// PID fan speed controller.
// s_ channel: one request per control tick, s_tdata = period_ticks, the
// tachometer period in 62.5 kHz timer ticks (low PERIOD_BITS bits used).
// m_ channel: one result per request; m_tdata holds pwm_duty, speed_rpm and
// scope_level. cfg_ channel: register writes (index 0 setpoint, 1 kp, 2 ki,
// 3 kd; other indexes ignored), always ready; the user must write only while
// the block is idle, which the block itself does not enforce.
// Steps after a request is taken: the bit-per-cycle restoring divider for
// the speed, error and error sum, four passes through one shared 17x33
// multiplier (ki*sum, kp*e, kd*de, speed scaling) and formatting the result.
// A new request is taken only once the previous one is done;
// s_tready is low while a request is being worked on.
// The result sits in an output register; a new request is taken while it
// waits. If the receiver stalls, the next finished result waits in the
// last step until the register frees up.
// Reset (aresetn low, synchronous) restores the register defaults, clears
// the previous error and the error sum, and drops m_tvalid.
module fan_speed_pid_controller_top #(
    parameter int unsigned PERIOD_BITS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [fsc_pkg::PERIOD_IN_W-1:0] s_tdata,   // [15:0] period_ticks
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [7:0] pwm_duty, [23:8] speed_rpm, [31:24] scope_level
    output logic [fsc_pkg::OUT_W-1:0]       m_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [fsc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fsc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import fsc_pkg::*;

    localparam int unsigned PW     = (PERIOD_BITS < PERIOD_IN_W) ? PERIOD_BITS : PERIOD_IN_W;
    localparam int unsigned DW     = PW + 3;
    localparam int unsigned CNT_W  = $clog2(NUM_W);
    localparam int unsigned PROD_W = 50;
    localparam int unsigned ACC_W  = 40;
    localparam logic signed [PROD_W-1:0] I_HI = PROD_W'(I_LIMIT);
    localparam logic signed [PROD_W-1:0] I_LO = -I_HI;

    typedef enum logic [2:0] {
        ST_IDLE, ST_DIV, ST_ERR, ST_SUM, ST_MUL_I, ST_MUL_P, ST_MUL_D, ST_DONE
    } state_t;

    state_t state_reg;

    logic [15:0] setpoint_reg, kp_reg, ki_reg, kd_reg;
    logic signed [17:0] last_error_reg;
    logic signed [31:0] error_sum_reg;

    logic [DW-1:0]      div_reg, rem_reg;
    logic [NUM_W-1:0]   quo_reg;
    logic               zero_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [15:0]        speed_reg;
    logic signed [17:0] err_reg;
    logic signed [18:0] diff_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic               m_tvalid_reg;
    logic [OUT_W-1:0]   m_tdata_reg;
    logic               mul_s_done_reg;

    logic [PW-1:0]      period;
    logic [DW:0]        trial, trial_sub;
    logic               trial_ge;
    logic [15:0]        speed_c;
    logic signed [17:0] err_c;
    logic signed [18:0] diff_c;
    logic               same_sign;
    logic signed [32:0] sum_c;
    logic signed [31:0] sum_sat;
    logic signed [16:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [PROD_W-1:0] iterm_c;
    logic [7:0]         duty_c, level_c;
    logic               out_free;

    assign period    = s_tdata[PW-1:0];
    assign trial     = {rem_reg, quo_reg[NUM_W-1]};
    assign trial_sub = trial - {1'b0, div_reg};
    assign trial_ge  = (trial >= {1'b0, div_reg});

    assign speed_c = (zero_reg || (|quo_reg[NUM_W-1:16])) ? SPEED_MAX : quo_reg[15:0];
    assign err_c   = $signed({2'b00, setpoint_reg}) - $signed({2'b00, speed_c});
    assign diff_c  = {err_c[17], err_c} - {last_error_reg[17], last_error_reg};

    assign same_sign = ((err_reg > 0) && (last_error_reg > 0)) ||
                       ((err_reg < 0) && (last_error_reg < 0));
    assign sum_c = {error_sum_reg[31], error_sum_reg} + 33'(err_reg);

    always_comb begin
        if (sum_c[32] != sum_c[31]) begin
            sum_sat = sum_c[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
        end else begin
            sum_sat = sum_c[31:0];
        end
    end

    always_comb begin
        case (state_reg)
            ST_MUL_I: begin
                mul_a = {1'b0, ki_reg};
                mul_b = 33'(error_sum_reg);
            end
            ST_MUL_P: begin
                mul_a = {1'b0, kp_reg};
                mul_b = 33'(err_reg);
            end
            ST_MUL_D: begin
                mul_a = {1'b0, kd_reg};
                mul_b = 33'(diff_reg);
            end
            ST_DONE: begin
                mul_a = {1'b0, SCOPE_MUL};
                mul_b = {17'd0, speed_reg};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_comb begin
        if (prod_reg > I_HI) begin
            iterm_c = I_HI;
        end else if (prod_reg < I_LO) begin
            iterm_c = I_LO;
        end else begin
            iterm_c = prod_reg;
        end
    end

    always_comb begin
        if (acc_reg < 0) begin
            duty_c = '0;
        end else if (|acc_reg[ACC_W-1:16]) begin
            duty_c = LEVEL_MAX;
        end else begin
            duty_c = acc_reg[15:8];
        end
    end

    assign level_c  = (|prod_reg[PROD_W-1:24]) ? LEVEL_MAX : prod_reg[23:16];
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            setpoint_reg   <= SETPOINT_RST;
            kp_reg         <= GAIN_PROP_RST;
            ki_reg         <= GAIN_INTEGRAL_RST;
            kd_reg         <= GAIN_DERIV_RST;
            last_error_reg <= '0;
            error_sum_reg  <= '0;
            cnt_reg        <= '0;
            m_tvalid_reg   <= 1'b0;
            mul_s_done_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    REG_SETPOINT:      setpoint_reg <= cfg_data;
                    REG_GAIN_PROP:     kp_reg       <= cfg_data;
                    REG_GAIN_INTEGRAL: ki_reg       <= cfg_data;
                    REG_GAIN_DERIV:    kd_reg       <= cfg_data;
                    default: ;
                endcase
            end

            // a result loaded in this cycle keeps m_tvalid high
            if (m_tvalid_reg && m_tready &&
                !(state_reg == ST_DONE && mul_s_done_reg)) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        div_reg   <= {period, 3'b000} - {3'b000, period};
                        zero_reg  <= (period == '0);
                        rem_reg   <= '0;
                        quo_reg   <= SPEED_NUM;
                        cnt_reg   <= '0;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    rem_reg <= trial_ge ? trial_sub[DW-1:0] : trial[DW-1:0];
                    quo_reg <= {quo_reg[NUM_W-2:0], trial_ge};
                    if (cnt_reg == CNT_W'(NUM_W - 1)) begin
                        state_reg <= ST_ERR;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_ERR: begin
                    speed_reg <= speed_c;
                    err_reg   <= err_c;
                    diff_reg  <= diff_c;
                    state_reg <= ST_SUM;
                end
                ST_SUM: begin
                    error_sum_reg  <= same_sign ? sum_sat : '0;
                    last_error_reg <= err_reg;
                    state_reg      <= ST_MUL_I;
                end
                ST_MUL_I: begin
                    prod_reg  <= mul_p;
                    state_reg <= ST_MUL_P;
                end
                ST_MUL_P: begin
                    acc_reg   <= iterm_c[ACC_W-1:0];
                    prod_reg  <= mul_p;
                    state_reg <= ST_MUL_D;
                end
                ST_MUL_D: begin
                    acc_reg        <= acc_reg + prod_reg[ACC_W-1:0];
                    prod_reg       <= mul_p;
                    mul_s_done_reg <= 1'b0;
                    state_reg      <= ST_DONE;
                end
                ST_DONE: begin
                    if (!mul_s_done_reg) begin
                        acc_reg        <= acc_reg + prod_reg[ACC_W-1:0];
                        prod_reg       <= mul_p;
                        mul_s_done_reg <= 1'b1;
                    end else if (out_free) begin
                        m_tdata_reg  <= {level_c, speed_reg, duty_c};
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign cfg_ready = 1'b1;

endmodule

### rtl/core/fsc_checker.sv
module fsc_checker (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_tvalid,
    input logic                      s_tready,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [fsc_pkg::OUT_W-1:0] m_tdata
);
    import fsc_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_busy_after_req: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result without work in flight");

    a_level_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[23:8] >= SCOPE_SAT_SPEED) |-> m_tdata[31:24] == LEVEL_MAX)
        else $error("scope level not saturated");

endmodule

bind fan_speed_pid_controller_top fsc_checker u_fsc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### tb/fsc_result_checker.sv
`timescale 1ns / 1ps

module fsc_result_checker #(
    parameter int unsigned PERIOD_BITS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [fsc_pkg::PERIOD_IN_W-1:0] s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [fsc_pkg::OUT_W-1:0]       m_tdata,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [fsc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fsc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                              mismatch_count,
    output int                              results_owed
);

    import fsc_pkg::*;

    localparam longint TICKS_PER_MIN = 3750000;
    localparam longint TACH_PULSES   = 7;
    localparam longint RPM_CEIL      = 65535;
    localparam longint ITERM_CAP     = 50 * 256;
    localparam longint DUTY_CEIL     = 255;
    localparam longint SCOPE_GAIN    = 5590;
    localparam longint LEVEL_CEIL    = 255;
    localparam longint SUM_HI        = 2147483647;
    localparam longint SUM_LO        = -SUM_HI - 1;

    // same layout as m_tdata
    typedef struct packed {
        logic [7:0]  scope_level;
        logic [15:0] speed_rpm;
        logic [7:0]  pwm_duty;
    } tick_result_t;

    logic [15:0]        setpoint_rpm;
    logic [15:0]        gain_prop;
    logic [15:0]        gain_integral;
    logic [15:0]        gain_deriv;
    logic signed [17:0] prior_error;
    int                 error_sum;

    tick_result_t tick_results_q[$];
    int           fail_count = 0;

    assign mismatch_count = fail_count;

    function automatic tick_result_t control_tick(input logic [fsc_pkg::PERIOD_IN_W-1:0] raw);
        longint       period;
        longint       rpm;
        longint       err;
        longint       prev;
        longint       acc;
        longint       iterm;
        longint       cf;
        longint       duty;
        longint       level;
        tick_result_t r;
        period = longint'(raw) & ((longint'(1) << PERIOD_BITS) - 1);
        if (period == 0) begin
            rpm = RPM_CEIL;
        end else begin
            rpm = TICKS_PER_MIN / (period * TACH_PULSES);
            if (rpm > RPM_CEIL) rpm = RPM_CEIL;
        end
        err  = longint'(setpoint_rpm) - rpm;
        prev = longint'(prior_error);
        if ((err > 0 && prev > 0) || (err < 0 && prev < 0)) begin
            acc = longint'(error_sum) + err;
            if (acc > SUM_HI) acc = SUM_HI;
            if (acc < SUM_LO) acc = SUM_LO;
            error_sum = int'(acc);
        end else begin
            error_sum = 0;
        end
        iterm = longint'(gain_integral) * longint'(error_sum);
        if (iterm > ITERM_CAP) iterm = ITERM_CAP;
        if (iterm < -ITERM_CAP) iterm = -ITERM_CAP;
        cf = longint'(gain_prop) * err + longint'(gain_deriv) * (err - prev) + iterm;
        if (cf < 0) begin
            duty = 0;
        end else begin
            duty = cf >>> 8;
            if (duty > DUTY_CEIL) duty = DUTY_CEIL;
        end
        level = (rpm * SCOPE_GAIN) >>> 16;
        if (level > LEVEL_CEIL) level = LEVEL_CEIL;
        prior_error   = err[17:0];
        r.pwm_duty    = duty[7:0];
        r.speed_rpm   = rpm[15:0];
        r.scope_level = level[7:0];
        return r;
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            fail_count++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        tick_result_t got;
        tick_result_t want;
        if (!aresetn) begin
            setpoint_rpm  = SETPOINT_RST;
            gain_prop     = GAIN_PROP_RST;
            gain_integral = GAIN_INTEGRAL_RST;
            gain_deriv    = GAIN_DERIV_RST;
            prior_error   = '0;
            error_sum     = 0;
            tick_results_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_SETPOINT:      setpoint_rpm  = cfg_data;
                    REG_GAIN_PROP:     gain_prop     = cfg_data;
                    REG_GAIN_INTEGRAL: gain_integral = cfg_data;
                    REG_GAIN_DERIV:    gain_deriv    = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                tick_results_q.push_back(control_tick(s_tdata));
            if (m_tvalid && m_tready) begin
                got = tick_result_t'(m_tdata);
                if (tick_results_q.size() == 0) begin
                    fail_count++;
                    $error("result with no request pending: m_tdata %h", m_tdata);
                end else begin
                    want = tick_results_q.pop_front();
                    check_field("pwm_duty", longint'(want.pwm_duty),
                                longint'(got.pwm_duty));
                    check_field("speed_rpm", longint'(want.speed_rpm),
                                longint'(got.speed_rpm));
                    check_field("scope_level", longint'(want.scope_level),
                                longint'(got.scope_level));
                end
            end
        end
        results_owed <= tick_results_q.size();
    end

    final begin
        if (tick_results_q.size() != 0)
            $error("%0d results never arrived", tick_results_q.size());
    end

endmodule

### tb/tb_fan_speed_pid_controller_top.sv
`timescale 1ns / 1ps

module tb_fan_speed_pid_controller_top;

    import fsc_pkg::*;

    localparam int unsigned PERIOD_BITS = 16;
    localparam logic [CFG_IDX_W-1:0] REG_PAST_END  = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_INDEX = 8'hFF;
    localparam int CYCLE_LIMIT   = 4000000;
    localparam int HOLD_CYCLES   = 600;
    localparam int CHUNK_ITEMS   = 140;
    localparam int SAT_RUN_ITEMS = 60;
    localparam int RPM_PER_TICK  = 535714;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [PERIOD_IN_W-1:0] s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_W-1:0]       m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    int mismatch_count;
    int results_owed;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_token = 0;
    int nominal_period = 535;
    int cycle_count = 0;

    always #6 aclk = ~aclk;

    fan_speed_pid_controller_top #(
        .PERIOD_BITS(PERIOD_BITS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    fsc_result_checker #(
        .PERIOD_BITS(PERIOD_BITS)
    ) checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatch_count(mismatch_count),
        .results_owed  (results_owed)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off each time hold_token moves
    initial begin
        int hold_seen;
        hold_seen = 0;
        forever begin
            @(posedge aclk);
            if (hold_token != hold_seen) begin
                hold_seen = hold_token;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge aclk);
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    task automatic send_period(input logic [PERIOD_IN_W-1:0] p);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= p;
        do @(posedge aclk); while (!s_tready);
    endtask

    // sender pauses until every request has its result
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (results_owed != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic load_gains(input int sp, input int kp, input int ki, input int kd);
        write_reg(REG_SETPOINT, sp[15:0]);
        write_reg(REG_GAIN_PROP, kp[15:0]);
        write_reg(REG_GAIN_INTEGRAL, ki[15:0]);
        write_reg(REG_GAIN_DERIV, kd[15:0]);
        nominal_period = (sp < 9) ? 65000 : RPM_PER_TICK / sp;
    endtask

    task automatic pick_setting(input int k);
        case (k % 4)
            0: load_gains($urandom_range(300, 5000), $urandom_range(0, 2048),
                          $urandom_range(0, 256), $urandom_range(0, 512));
            1: load_gains(65535, 65535, 65535, 65535);
            2: load_gains($urandom_range(0, 65535), $urandom_range(0, 65535),
                          $urandom_range(0, 65535), $urandom_range(0, 65535));
            default: load_gains(0, 0, 0, 0);
        endcase
    endtask

    // mostly periods around the setpoint so the error sum builds up
    function automatic logic [PERIOD_IN_W-1:0] next_tach_period();
        int r;
        int span;
        int v;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            span = nominal_period / 16 + 2;
            v = $urandom_range(0, 2 * span);
            v = nominal_period + v - span;
            if (v < 0) v = 0;
            if (v > 65535) v = 65535;
        end else if (r < 85) begin
            v = $urandom_range(0, 65535);
        end else if (r < 93) begin
            v = $urandom_range(0, 8);
        end else begin
            v = $urandom_range(50000, 65535);
        end
        return v[15:0];
    endfunction

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // register defaults: saturated speeds, zero period, sign changes
        send_period(16'd0);
        send_period(16'd1);
        send_period(16'd7);
        send_period(16'd8);
        send_period(16'hFFFF);
        send_period(16'h5555);
        send_period(16'hAAAA);
        send_period(16'd535);
        send_period(16'd535);
        send_period(16'd535);
        send_period(16'd536);
        send_period(16'd536);
        send_period(16'd2000);
        send_period(16'd2000);
        send_period(16'd100);
        drain();

        // zero error, then previous error zero
        write_reg(REG_SETPOINT, 16'd999);
        send_period(16'd536);
        send_period(16'd536);
        send_period(16'd535);
        drain();

        write_reg(REG_PAST_END, 16'h1234);
        write_reg(REG_TOP_INDEX, 16'hFFFF);
        load_gains(65535, 65535, 65535, 65535);
        send_period(16'd0);
        send_period(16'hFFFF);
        send_period(16'd1);
        drain();
        load_gains(0, 0, 0, 0);
        send_period(16'd1000);
        send_period(16'd0);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle_pct = 20; recv_idle_pct = 85; end
                1: begin send_idle_pct = 85; recv_idle_pct = 20; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (int chunk = 0; chunk < 3; chunk++) begin
                drain();
                pick_setting(phase * 3 + chunk);
                for (int n = 0; n < CHUNK_ITEMS; n++) begin
                    if (phase == 0 && chunk == 0 && n == 40)
                        hold_token <= hold_token + 1;
                    send_period(next_tach_period());
                end
            end
        end

        // long positive error run builds up the error sum
        drain();
        load_gains(65535, 0, 1, 0);
        for (int n = 0; n < SAT_RUN_ITEMS; n++)
            send_period(16'hFFFF);

        drain();
        repeat (40) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
